// ===== hw/rtl/m6502_pkg.sv =====
`default_nettype none
package m6502_pkg;

  localparam logic [1:0] WK_NONE = 2'd0;
  localparam logic [1:0] WK_MEM  = 2'd1;
  localparam logic [1:0] WK_PUSH = 2'd2;

  localparam logic [7:0] FL_N = 8'h80;
  localparam logic [7:0] FL_V = 8'h40;
  localparam logic [7:0] FL_B = 8'h10;
  localparam logic [7:0] FL_D = 8'h08;
  localparam logic [7:0] FL_I = 8'h04;
  localparam logic [7:0] FL_Z = 8'h02;
  localparam logic [7:0] FL_C = 8'h01;
  localparam logic [7:0] FL_MASK = 8'hDF;
  localparam logic [7:0] FL_UNUSED = 8'h20;
  localparam logic [7:0] PHP_BITS = 8'h30;
  localparam logic [7:0] SP_RESET = 8'hFF;

  localparam logic [7:0] OP_JSR = 8'h20;
  localparam logic [7:0] OP_RTS = 8'h60;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [7:0]  operand_data;
    logic [15:0] operand_word;
  } instr_t;

  typedef struct packed {
    logic [1:0]  write_kind;
    logic [7:0]  write_data;
    logic [15:0] return_address;
    logic [7:0]  acc_value;
    logic [7:0]  x_value;
    logic [7:0]  y_value;
    logic [7:0]  sp_value;
    logic [7:0]  status_value;
    logic [15:0] next_pc;
  } result_t;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [15:0] pc;
    logic [7:0]  p;
  } arch_t;

  function automatic logic [1:0] instr_len(input logic [7:0] op);
    logic [2:0] mode;
    logic [1:0] grp;
    logic [1:0] len;
    mode = op[4:2];
    grp  = op[1:0];
    if (op == OP_JSR || mode == 3'd3 || mode == 3'd7) len = 2'd3;
    else if (mode == 3'd0) len = (op == OP_RTS) ? 2'd1 : 2'd2;
    else if (mode == 3'd2) len = (grp == 2'd1) ? 2'd2 : 2'd1;
    else if (mode == 3'd6) len = (grp == 2'd1) ? 2'd3 : 2'd1;
    else len = 2'd2;
    return len;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/m6502_if.sv =====
`default_nettype none
interface m6502_instr_if import m6502_pkg::*; ();
  logic   valid;
  logic   ready;
  instr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface m6502_result_if import m6502_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/m6502_alu.sv =====
`default_nettype none
module m6502_alu import m6502_pkg::*; (
  input  var instr_t  instr,
  input  var arch_t   cur,
  output arch_t       nxt,
  output result_t     res
);

  logic [7:0]  d, a, x, y, sp, p, wd, sh_in, sh_out, bin;
  logic [15:0] pc, next, ret;
  logic [1:0]  wk;
  logic [8:0]  sum;
  logic        cin, flag, taken;

  function automatic logic [7:0] nz(input logic [7:0] f, input logic [7:0] v);
    return (f & ~(FL_N | FL_Z)) | (v & FL_N) | ((v == 8'h00) ? FL_Z : 8'h00);
  endfunction

  always_comb begin
    d = instr.operand_data;
    a = cur.a; x = cur.x; y = cur.y; sp = cur.sp; p = cur.p;
    pc = cur.pc;
    next = cur.pc + {14'd0, instr_len(instr.opcode)};
    wk = WK_NONE; wd = 8'h00; ret = 16'h0000;
    cin = cur.p[0];
    bin = (instr.opcode[7:5] == 3'b111) ? ~d : d;
    sum = {1'b0, cur.a} + {1'b0, bin} + {8'd0, cin};
    sh_in = (instr.opcode[3:0] == 4'hA) ? cur.a : d;
    sh_out = instr.opcode[6] ? {instr.opcode[5] & cin, sh_in[7:1]}
                             : {sh_in[6:0], instr.opcode[5] & cin};
    unique case (instr.opcode[7:6])
      2'd0: flag = cur.p[7];
      2'd1: flag = cur.p[6];
      2'd2: flag = cur.p[0];
      default: flag = cur.p[1];
    endcase
    taken = (flag == instr.opcode[5]);

    unique case (instr.opcode)
      8'h09, 8'h05, 8'h15, 8'h01, 8'h11, 8'h0D, 8'h1D, 8'h19: begin
        a = cur.a | d; p = nz(p, a);
      end
      8'h29, 8'h25, 8'h35, 8'h21, 8'h31, 8'h2D, 8'h3D, 8'h39: begin
        a = cur.a & d; p = nz(p, a);
      end
      8'h49, 8'h45, 8'h55, 8'h41, 8'h51, 8'h4D, 8'h5D, 8'h59: begin
        a = cur.a ^ d; p = nz(p, a);
      end
      8'h69, 8'h65, 8'h75, 8'h61, 8'h71, 8'h6D, 8'h7D, 8'h79,
      8'hE9, 8'hE5, 8'hF5, 8'hE1, 8'hF1, 8'hED, 8'hFD, 8'hF9: begin
        a = sum[7:0];
        p[6] = ~(cur.a[7] ^ bin[7]) & (cur.a[7] ^ sum[7]);
        p[0] = sum[8];
        p = nz(p, a);
      end
      8'hC9, 8'hC5, 8'hD5, 8'hC1, 8'hD1, 8'hCD, 8'hDD, 8'hD9: begin
        p[0] = cur.a >= d; p = nz(p, cur.a - d);
      end
      8'hE0, 8'hE4, 8'hEC: begin
        p[0] = cur.x >= d; p = nz(p, cur.x - d);
      end
      8'hC0, 8'hC4, 8'hCC: begin
        p[0] = cur.y >= d; p = nz(p, cur.y - d);
      end
      8'hA9, 8'hA5, 8'hB5, 8'hA1, 8'hB1, 8'hAD, 8'hBD, 8'hB9: begin
        a = d; p = nz(p, d);
      end
      8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE: begin x = d; p = nz(p, d); end
      8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC: begin y = d; p = nz(p, d); end
      8'h85, 8'h95, 8'h81, 8'h91, 8'h8D, 8'h9D, 8'h99: begin
        wk = WK_MEM; wd = cur.a;
      end
      8'h86, 8'h96, 8'h8E: begin wk = WK_MEM; wd = cur.x; end
      8'h84, 8'h94, 8'h8C: begin wk = WK_MEM; wd = cur.y; end
      8'h0A, 8'h2A, 8'h4A, 8'h6A: begin
        a = sh_out; p[0] = instr.opcode[6] ? sh_in[0] : sh_in[7]; p = nz(p, sh_out);
      end
      8'h06, 8'h16, 8'h0E, 8'h1E, 8'h26, 8'h36, 8'h2E, 8'h3E,
      8'h46, 8'h56, 8'h4E, 8'h5E, 8'h66, 8'h76, 8'h6E, 8'h7E: begin
        wk = WK_MEM; wd = sh_out;
        p[0] = instr.opcode[6] ? sh_in[0] : sh_in[7]; p = nz(p, sh_out);
      end
      8'hC6, 8'hD6, 8'hCE, 8'hDE: begin wk = WK_MEM; wd = d - 8'd1; p = nz(p, wd); end
      8'hE6, 8'hF6, 8'hEE, 8'hFE: begin wk = WK_MEM; wd = d + 8'd1; p = nz(p, wd); end
      8'h24, 8'h2C: begin
        p[1] = (cur.a & d) == 8'h00; p[7] = d[7]; p[6] = d[6];
      end
      8'hAA: begin x = cur.a; p = nz(p, x); end
      8'hA8: begin y = cur.a; p = nz(p, y); end
      8'hBA: begin x = cur.sp; p = nz(p, x); end
      8'h8A: begin a = cur.x; p = nz(p, a); end
      8'h98: begin a = cur.y; p = nz(p, a); end
      8'h9A: sp = cur.x;
      8'hCA: begin x = cur.x - 8'd1; p = nz(p, x); end
      8'h88: begin y = cur.y - 8'd1; p = nz(p, y); end
      8'hE8: begin x = cur.x + 8'd1; p = nz(p, x); end
      8'hC8: begin y = cur.y + 8'd1; p = nz(p, y); end
      8'h48: begin wk = WK_PUSH; wd = cur.a; sp = cur.sp - 8'd1; end
      8'h08: begin wk = WK_PUSH; wd = cur.p | PHP_BITS; sp = cur.sp - 8'd1; end
      8'h68: begin sp = cur.sp + 8'd1; a = d; p = nz(p, d); end
      8'h28: begin sp = cur.sp + 8'd1; p = d & FL_MASK; end
      8'h4C, 8'h6C: next = instr.operand_word;
      OP_JSR: begin
        wk = WK_PUSH; ret = pc + 16'd2; sp = cur.sp - 8'd2; next = instr.operand_word;
      end
      OP_RTS: begin sp = cur.sp + 8'd2; next = instr.operand_word + 16'd1; end
      8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: begin
        if (taken) next = pc + 16'd2 + {{8{d[7]}}, d};
      end
      8'h18: p[0] = 1'b0;
      8'h38: p[0] = 1'b1;
      8'h58: p[2] = 1'b0;
      8'h78: p[2] = 1'b1;
      8'hB8: p[6] = 1'b0;
      8'hD8: p[3] = 1'b0;
      8'hF8: p[3] = 1'b1;
      8'hEA: ;
      default: next = pc + 16'd1;
    endcase

    nxt = '{a: a, x: x, y: y, sp: sp, pc: next, p: p & FL_MASK};
    res = '{write_kind: wk, write_data: wd, return_address: ret, acc_value: a,
            x_value: x, y_value: y, sp_value: sp,
            status_value: (p & FL_MASK) | FL_UNUSED, next_pc: next};
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mos6502_execute_unit.sv =====
`default_nettype none
// A result is registered: an instruction accepted at a clock edge shows its result
// in the following cycle. Throughput: one instruction per cycle while the consumer
// keeps up; the architectural registers sit in a loop through the ALU alone.
// Reset: synchronous, active low; A, X, Y, PC and flags clear, SP becomes 0xFF,
// no result is valid.
module mos6502_execute_unit import m6502_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  m6502_instr_if.sink      in_ch,
  m6502_result_if.source   out_ch
);

  arch_t   arch_r, arch_nxt;
  result_t res_nxt, res_r;
  logic    vld_r;
  logic    in_fire;

  // Output register is free when empty or being drained in this cycle, so
  // instructions stream one per cycle while the consumer keeps up.
  assign in_ch.ready = !vld_r || out_ch.ready;
  assign in_fire = in_ch.valid && in_ch.ready;

  m6502_alu u_alu (
    .instr (in_ch.data),
    .cur   (arch_r),
    .nxt   (arch_nxt),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_r <= '{a: 8'h00, x: 8'h00, y: 8'h00, sp: SP_RESET, pc: 16'h0000, p: 8'h00};
      vld_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        arch_r <= arch_nxt;
        vld_r  <= 1'b1;
      end else if (out_ch.ready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) res_r <= res_nxt;
  end

  assign out_ch.valid = vld_r;
  assign out_ch.data  = res_r;

  // The result shown matches the architectural state it came from, has status bit 5 set and holds while stalled.
  a_pc_match: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> res_r.next_pc == arch_r.pc) else $error("pc mismatch");
  a_status_bit5: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> res_r.status_value[5]) else $error("status bit 5 clear");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !out_ch.ready |=> vld_r && $stable(res_r)) else $error("result lost");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
module testbench;
  import m6502_pkg::*;

  // Clock and reset.
  logic clk;
  logic rst_n;

  m6502_instr_if  instr_ch ();
  m6502_result_if result_ch ();

  mos6502_execute_unit uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (instr_ch.sink),
    .out_ch(result_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Architectural state of the predictor.
  logic [7:0]  pa, px, py, psp, pflags;
  logic [15:0] ppc;

  instr_t  pending_instrs[$];
  result_t expected_results[$];

  int errors;
  int accepted_instrs;
  int checked_results;
  int taken_branches;
  int idle_pct;
  bit hold_sender;
  bit all_queued;
  int stall_cycles;

  // Instruction length from the opcode's addressing-mode bits.
  function automatic logic [15:0] opcode_bytes(input logic [7:0] op);
    logic [2:0] mode;
    mode = op[4:2];
    if (op == OP_JSR || mode == 3'd3 || mode == 3'd7) return 16'd3;
    if (mode == 3'd0) return (op == OP_RTS) ? 16'd1 : 16'd2;
    if (mode == 3'd2) return (op[1:0] == 2'd1) ? 16'd2 : 16'd1;
    if (mode == 3'd6) return (op[1:0] == 2'd1) ? 16'd3 : 16'd1;
    return 16'd2;
  endfunction

  function automatic void update_nz(input logic [7:0] v);
    pflags[7] = v[7];
    pflags[1] = (v == 8'h00);
  endfunction

  function automatic void add_to_acc(input logic [7:0] v);
    logic [8:0] sum;
    sum = {1'b0, pa} + {1'b0, v} + {8'h00, pflags[0]};
    pflags[6] = (~(pa[7] ^ v[7])) & (pa[7] ^ sum[7]);
    pflags[0] = sum[8];
    pa = sum[7:0];
    update_nz(pa);
  endfunction

  function automatic void compare_reg(input logic [7:0] r, input logic [7:0] v);
    pflags[0] = (r >= v);
    update_nz(r - v);
  endfunction

  // Kinds: 0 shift left, 1 rotate left, 2 shift right, 3 rotate right.
  function automatic logic [7:0] shift_byte(input logic [7:0] v, input logic [1:0] kind);
    logic [7:0] r;
    logic cin;
    cin = pflags[0];
    if (!kind[1]) begin
      r = {v[6:0], kind[0] ? cin : 1'b0};
      pflags[0] = v[7];
    end else begin
      r = {kind[0] ? cin : 1'b0, v[7:1]};
      pflags[0] = v[0];
    end
    update_nz(r);
    return r;
  endfunction

  // Executes one instruction on the predictor state and returns what the
  // block should report for it.
  function automatic result_t execute_instr(input instr_t ins);
    result_t r;
    logic [7:0]  op, d;
    logic [15:0] nxt;
    logic        flag;
    op = ins.opcode;
    d  = ins.operand_data;
    r  = '0;
    r.write_kind = WK_NONE;
    nxt = ppc + opcode_bytes(op);
    case (op)
      8'h09, 8'h05, 8'h15, 8'h01, 8'h11, 8'h0D, 8'h1D, 8'h19: begin
        pa = pa | d; update_nz(pa);
      end
      8'h29, 8'h25, 8'h35, 8'h21, 8'h31, 8'h2D, 8'h3D, 8'h39: begin
        pa = pa & d; update_nz(pa);
      end
      8'h49, 8'h45, 8'h55, 8'h41, 8'h51, 8'h4D, 8'h5D, 8'h59: begin
        pa = pa ^ d; update_nz(pa);
      end
      8'h69, 8'h65, 8'h75, 8'h61, 8'h71, 8'h6D, 8'h7D, 8'h79: add_to_acc(d);
      8'hE9, 8'hE5, 8'hF5, 8'hE1, 8'hF1, 8'hED, 8'hFD, 8'hF9: add_to_acc(~d);
      8'hC9, 8'hC5, 8'hD5, 8'hC1, 8'hD1, 8'hCD, 8'hDD, 8'hD9: compare_reg(pa, d);
      8'hE0, 8'hE4, 8'hEC: compare_reg(px, d);
      8'hC0, 8'hC4, 8'hCC: compare_reg(py, d);
      8'hA9, 8'hA5, 8'hB5, 8'hA1, 8'hB1, 8'hAD, 8'hBD, 8'hB9: begin
        pa = d; update_nz(d);
      end
      8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE: begin px = d; update_nz(d); end
      8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC: begin py = d; update_nz(d); end
      8'h85, 8'h95, 8'h81, 8'h91, 8'h8D, 8'h9D, 8'h99: begin
        r.write_kind = WK_MEM; r.write_data = pa;
      end
      8'h86, 8'h96, 8'h8E: begin r.write_kind = WK_MEM; r.write_data = px; end
      8'h84, 8'h94, 8'h8C: begin r.write_kind = WK_MEM; r.write_data = py; end
      8'h0A, 8'h2A, 8'h4A, 8'h6A: pa = shift_byte(pa, op[6:5]);
      8'h06, 8'h16, 8'h0E, 8'h1E, 8'h26, 8'h36, 8'h2E, 8'h3E,
      8'h46, 8'h56, 8'h4E, 8'h5E, 8'h66, 8'h76, 8'h6E, 8'h7E: begin
        r.write_kind = WK_MEM; r.write_data = shift_byte(d, op[6:5]);
      end
      8'hC6, 8'hD6, 8'hCE, 8'hDE: begin
        r.write_kind = WK_MEM; r.write_data = d - 8'd1; update_nz(r.write_data);
      end
      8'hE6, 8'hF6, 8'hEE, 8'hFE: begin
        r.write_kind = WK_MEM; r.write_data = d + 8'd1; update_nz(r.write_data);
      end
      8'h24, 8'h2C: begin
        pflags[1] = ((pa & d) == 8'h00);
        pflags[7] = d[7];
        pflags[6] = d[6];
      end
      8'hAA: begin px = pa; update_nz(px); end
      8'hA8: begin py = pa; update_nz(py); end
      8'hBA: begin px = psp; update_nz(px); end
      8'h8A: begin pa = px; update_nz(pa); end
      8'h98: begin pa = py; update_nz(pa); end
      8'h9A: psp = px;
      8'hCA: begin px = px - 8'd1; update_nz(px); end
      8'h88: begin py = py - 8'd1; update_nz(py); end
      8'hE8: begin px = px + 8'd1; update_nz(px); end
      8'hC8: begin py = py + 8'd1; update_nz(py); end
      8'h48: begin r.write_kind = WK_PUSH; r.write_data = pa; psp = psp - 8'd1; end
      8'h08: begin
        r.write_kind = WK_PUSH; r.write_data = pflags | PHP_BITS; psp = psp - 8'd1;
      end
      8'h68: begin psp = psp + 8'd1; pa = d; update_nz(d); end
      8'h28: begin psp = psp + 8'd1; pflags = d & FL_MASK; end
      8'h4C, 8'h6C: nxt = ins.operand_word;
      OP_JSR: begin
        r.write_kind = WK_PUSH;
        r.return_address = ppc + 16'd2;
        psp = psp - 8'd2;
        nxt = ins.operand_word;
      end
      OP_RTS: begin
        psp = psp + 8'd2;
        nxt = ins.operand_word + 16'd1;
      end
      8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: begin
        // Condition flag chosen by the top two opcode bits: N, V, C, Z.
        case (op[7:6])
          2'd0: flag = pflags[7];
          2'd1: flag = pflags[6];
          2'd2: flag = pflags[0];
          default: flag = pflags[1];
        endcase
        if (flag == op[5]) begin
          nxt = ppc + 16'd2 + {{8{d[7]}}, d};
          taken_branches++;
        end
      end
      8'h18: pflags[0] = 1'b0;
      8'h38: pflags[0] = 1'b1;
      8'h58: pflags[2] = 1'b0;
      8'h78: pflags[2] = 1'b1;
      8'hB8: pflags[6] = 1'b0;
      8'hD8: pflags[3] = 1'b0;
      8'hF8: pflags[3] = 1'b1;
      8'hEA: ;
      // Unknown opcodes, BRK and RTI act as one-byte no-ops.
      default: nxt = ppc + 16'd1;
    endcase
    ppc = nxt;
    r.acc_value    = pa;
    r.x_value      = px;
    r.y_value      = py;
    r.sp_value     = psp;
    r.status_value = (pflags & FL_MASK) | FL_UNUSED;
    r.next_pc      = ppc;
    return r;
  endfunction

  function automatic instr_t make_instr(input logic [7:0] op, input logic [7:0] d,
                                        input logic [15:0] w);
    instr_t ins;
    ins.opcode = op;
    ins.operand_data = d;
    ins.operand_word = w;
    return ins;
  endfunction

  // Opcodes that the random part favors: every byte value but those
  // excluded below, BRK and RTI among them.
  logic [7:0] known_ops[$];

  initial begin
    instr_t ins;
    int k;
    // Build the opcode list from every byte value, leaving out only the nine
    // bytes listed in the empty branch, BRK and RTI among them.
    for (k = 0; k < 256; k++) begin
      case (k[7:0])
        8'h00, 8'h40, 8'h02, 8'h03, 8'h04, 8'h07, 8'h0B, 8'h0C, 8'h0F: ;
        default: known_ops.push_back(k[7:0]);
      endcase
    end

    // Directed part: loads at the extremes, add/subtract overflow, compares,
    // shifts through carry, BIT, stack, JSR/RTS, branches both ways, flags,
    // a store, a read-modify-write with wrap, TXS, an unknown opcode and JMP ind.
    pending_instrs.push_back(make_instr(8'hA9, 8'h7F, 16'h0000)); // LDA #$7F
    pending_instrs.push_back(make_instr(8'h69, 8'h01, 16'hFFFF)); // ADC overflow
    pending_instrs.push_back(make_instr(8'h69, 8'hFF, 16'h0000)); // ADC carry out
    pending_instrs.push_back(make_instr(8'hE9, 8'h80, 16'h0000)); // SBC
    pending_instrs.push_back(make_instr(8'hC9, 8'h00, 16'h0000)); // CMP
    pending_instrs.push_back(make_instr(8'hA2, 8'hFF, 16'h0000)); // LDX #$FF
    pending_instrs.push_back(make_instr(8'hE8, 8'h00, 16'h0000)); // INX wraps
    pending_instrs.push_back(make_instr(8'hA0, 8'h80, 16'h0000)); // LDY
    pending_instrs.push_back(make_instr(8'h6A, 8'h00, 16'h0000)); // ROR A
    pending_instrs.push_back(make_instr(8'h0A, 8'h00, 16'h0000)); // ASL A
    pending_instrs.push_back(make_instr(8'h2C, 8'hC0, 16'h1234)); // BIT abs
    pending_instrs.push_back(make_instr(8'h08, 8'h00, 16'h0000)); // PHP
    pending_instrs.push_back(make_instr(8'h28, 8'hFF, 16'h0000)); // PLP all ones
    pending_instrs.push_back(make_instr(8'h48, 8'h00, 16'h0000)); // PHA
    pending_instrs.push_back(make_instr(8'h20, 8'h00, 16'hFFFE)); // JSR
    pending_instrs.push_back(make_instr(8'h60, 8'h00, 16'hFFFF)); // RTS wraps pc
    pending_instrs.push_back(make_instr(8'hF0, 8'h80, 16'h0000)); // BEQ back
    pending_instrs.push_back(make_instr(8'hD0, 8'h7F, 16'h0000)); // BNE forward
    pending_instrs.push_back(make_instr(8'hF8, 8'h00, 16'h0000)); // SED
    pending_instrs.push_back(make_instr(8'h78, 8'h00, 16'h0000)); // SEI
    pending_instrs.push_back(make_instr(8'h8D, 8'h00, 16'h0000)); // STA abs
    pending_instrs.push_back(make_instr(8'hC6, 8'h00, 16'h0000)); // DEC wraps
    pending_instrs.push_back(make_instr(8'h9A, 8'h00, 16'h0000)); // TXS
    pending_instrs.push_back(make_instr(8'h02, 8'hFF, 16'hFFFF)); // unknown
    pending_instrs.push_back(make_instr(8'h6C, 8'h00, 16'h8000)); // JMP ind

    // Random part: mostly opcodes from known_ops, some from the full byte range.
    for (k = 0; k < 1330; k++) begin
      if ($urandom_range(0, 9) < 8)
        ins.opcode = known_ops[$urandom_range(0, known_ops.size() - 1)];
      else
        ins.opcode = $urandom_range(0, 255);
      ins.operand_data = $urandom_range(0, 255);
      ins.operand_word = $urandom_range(0, 65535);
      pending_instrs.push_back(ins);
    end
    all_queued = 1'b1;
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Idling is switched off for a stretch in the middle of the run.
  always_comb idle_pct = (accepted_instrs > 500 && accepted_instrs < 800) ? 0 : 17;

  // Driver: presents the next pending instruction, holding it until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      instr_ch.valid <= 1'b0;
      instr_ch.data  <= '0;
      hold_sender    <= 1'b0;
    end else begin
      automatic bit accepted = instr_ch.valid && instr_ch.ready;
      automatic bit busy = instr_ch.valid && !accepted;
      if (accepted) begin
        expected_results.push_back(execute_instr(instr_ch.data));
        accepted_instrs++;
        if (accepted_instrs == 300) hold_sender <= 1'b1;
      end
      // Once, the sender waits until every expected result has arrived.
      if (hold_sender && expected_results.size() == 0 && !accepted)
        hold_sender <= 1'b0;
      if (!busy) begin
        if (pending_instrs.size() > 0 && !hold_sender && !(accepted && accepted_instrs == 300)
            && $urandom_range(0, 99) >= idle_pct) begin
          instr_ch.valid <= 1'b1;
          instr_ch.data  <= pending_instrs.pop_front();
        end else begin
          instr_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure and field-by-field comparison.
  always @(posedge clk) begin
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: %h", $time, result_ch.data);
          errors++;
        end else begin
          automatic result_t want = expected_results.pop_front();
          automatic result_t got = result_ch.data;
          checked_results++;
          if (got.write_kind !== want.write_kind) begin
            $display("%0t: write_kind exp %h got %h", $time, want.write_kind, got.write_kind);
            errors++;
          end
          if (got.write_data !== want.write_data) begin
            $display("%0t: write_data exp %h got %h", $time, want.write_data, got.write_data);
            errors++;
          end
          if (got.return_address !== want.return_address) begin
            $display("%0t: return_address exp %h got %h", $time,
                     want.return_address, got.return_address);
            errors++;
          end
          if (got.acc_value !== want.acc_value) begin
            $display("%0t: acc_value exp %h got %h", $time, want.acc_value, got.acc_value);
            errors++;
          end
          if (got.x_value !== want.x_value) begin
            $display("%0t: x_value exp %h got %h", $time, want.x_value, got.x_value);
            errors++;
          end
          if (got.y_value !== want.y_value) begin
            $display("%0t: y_value exp %h got %h", $time, want.y_value, got.y_value);
            errors++;
          end
          if (got.sp_value !== want.sp_value) begin
            $display("%0t: sp_value exp %h got %h", $time,
                     want.sp_value, got.sp_value);
            errors++;
          end
          if (got.status_value !== want.status_value) begin
            $display("%0t: status_value exp %h got %h", $time,
                     want.status_value, got.status_value);
            errors++;
          end
          if (got.next_pc !== want.next_pc) begin
            $display("%0t: next_pc exp %h got %h", $time, want.next_pc, got.next_pc);
            errors++;
          end
        end
      end
      result_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= 2000) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    errors = 0;
    accepted_instrs = 0;
    checked_results = 0;
    taken_branches = 0;
    stall_cycles = 0;
    instr_ch.valid = 1'b0;
    instr_ch.data = '0;
    result_ch.ready = 1'b0;
    pa = 8'h00; px = 8'h00; py = 8'h00; psp = SP_RESET; ppc = 16'h0000; pflags = 8'h00;
    wait (all_queued);
    wait (pending_instrs.size() == 0 && !instr_ch.valid && expected_results.size() == 0);
    // The block registers each result; let the clock run on before the summary.
    repeat (10) @(posedge clk);
    $display("Ran %0d instructions, %0d results checked, %0d branches taken.",
             accepted_instrs, checked_results, taken_branches);
    if (errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
